### src/gear_cdc_regression_cutpoint_defines.svh
// assertion macros for the gear chunking block
`ifndef GEAR_CDC_REGRESSION_CUTPOINT_DEFINES_SVH
`define GEAR_CDC_REGRESSION_CUTPOINT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GCDC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcdc same-cycle check failed");

// next-cycle implication, disabled in reset
`define GCDC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcdc next-cycle check failed");

`endif

### src/gcdc_pkg.sv
// shared constants and types of the gear chunking block
package gcdc_pkg;

  localparam int LEN_BITS     = 21;
  localparam int HASH_W       = 64;
  localparam int HASH_SHIFTS  = $clog2(HASH_W);
  localparam int WARMUP_BYTES = 64;
  localparam int TABLE_DEPTH  = 256;
  localparam int BYTE_W       = 8;
  localparam int THRESH_W     = 32;
  localparam int PDATA_W      = 32;
  localparam int PADDR_W      = 4;

  localparam logic [LEN_BITS-1:0] MIN_SIZE_RST  = LEN_BITS'(2048);
  localparam logic [LEN_BITS-1:0] MAX_SIZE_RST  = LEN_BITS'(65536);
  localparam logic [THRESH_W-1:0] THRESHOLD_RST = THRESH_W'(262144);
  localparam logic [LEN_BITS-1:0] WARMUP_LEN    = LEN_BITS'(WARMUP_BYTES);

  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_TABLE = 1'b1;

  typedef enum logic [1:0] {
    REASON_SHORT   = 2'd0,
    REASON_THRESH  = 2'd1,
    REASON_REGRESS = 2'd2,
    REASON_WINDOW  = 2'd3
  } cut_reason_t;

  typedef enum logic [1:0] {
    REG_MIN_SIZE  = 2'd0,
    REG_MAX_SIZE  = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_index_t;

endpackage

### src/gcdc_chan_if.sv
// valid/ready channels for window bytes and cut results
interface gcdc_in_if;
  import gcdc_pkg::*;
  logic                valid;
  logic                ready;
  logic                func;
  logic [BYTE_W-1:0]   data_byte;
  logic                last;
  logic [BYTE_W-1:0]   table_index;
  logic [HASH_W-1:0]   table_value;

  modport source (output valid, func, data_byte, last, table_index, table_value,
                  input ready);
  modport sink   (input valid, func, data_byte, last, table_index, table_value,
                  output ready);
endinterface

interface gcdc_out_if;
  import gcdc_pkg::*;
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] cut_length;
  logic [1:0]          cut_reason;

  modport source (output valid, cut_length, cut_reason, input ready);
  modport sink   (input valid, cut_length, cut_reason, output ready);
endinterface

### src/gcdc_ram.sv
// generic single-write, single-read ram with registered read data
module gcdc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/gear_cdc_regression_cutpoint.sv
// gear hash chunk boundary search with regression points, top level
//
// Finds one content-defined chunk boundary. Window bytes (func 0) and gear
// table writes (func 1) arrive on byte_chan, one transaction per cycle at full
// rate unless a waiting result stalls the input; the 256-word gear table sits
// in a ram with a registered read, so a byte transaction issues its table read
// on acceptance and its hash update and boundary decision happen in the
// decision stage against the rolling hash registers. That update loop sets
// the rate, one transaction per clock while results are taken; a cut result
// turns valid on cut_chan once the decision stage has passed the byte that
// ends the chunk to the output register, which lets one more byte be taken
// while a result waits; a result that stays untaken then stalls the input.
// A table write takes effect for any byte accepted after it. The table is
// undefined until written and has no clearing pass; bytes must only refer to
// written entries. min_len, max_size and threshold sit at byte addresses 0,
// 4 and 8 of the apb port and may be changed only while no transaction is in
// flight. After every result the search state restarts for the next chunk.
module gear_cdc_regression_cutpoint (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gcdc_pkg::PADDR_W-1:0] paddr,
  input  logic [gcdc_pkg::PDATA_W-1:0] pwdata,
  output logic [gcdc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  gcdc_in_if.sink                      byte_chan,
  gcdc_out_if.source                   cut_chan
);
  import gcdc_pkg::*;

  // configuration registers
  logic [LEN_BITS-1:0] min_len;
  logic [LEN_BITS-1:0] max_size;
  logic [THRESH_W-1:0] threshold;
  reg_index_t          reg_sel;
  logic                cfg_write;

  // per-chunk search state
  logic [HASH_W-1:0]   rolling_hash;
  logic [HASH_W-1:0]   regress_mask;
  logic [LEN_BITS-1:0] regress_length;
  logic [LEN_BITS-1:0] byte_position;

  // decision stage and output register
  logic                s1_valid;
  logic                s1_last;
  logic                s1_go;
  logic                s1_cut;
  logic                take_regress;
  logic                out_valid;
  logic [LEN_BITS-1:0] out_len;
  cut_reason_t         out_reason;
  logic [LEN_BITS-1:0] cut_len;
  cut_reason_t         cut_reason;

  // input handshake
  logic                in_ready;
  logic                in_fire;
  logic                in_func;
  logic [HASH_W-1:0]   gear_word;

  // window geometry from the configuration
  logic [LEN_BITS-1:0] end_pos;
  logic [LEN_BITS-1:0] warm_start;

  // datapath of the decision stage
  logic [HASH_W-1:0]   hash_mixed;
  logic [HASH_W-1:0]   hash_smear;
  logic [HASH_W-1:0]   mask_tight;
  logic [LEN_BITS:0]   n_ext;
  logic                mask_clear;
  logic                below_thr;

  // terms for the checks
  logic                state_fresh;
  logic                regress_fits;

  // ---------------------------------------------------------------------
  // apb register port, always ready
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len   <= MIN_SIZE_RST;
      max_size  <= MAX_SIZE_RST;
      threshold <= THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_MIN_SIZE:  min_len   <= pwdata[LEN_BITS-1:0];
        REG_MAX_SIZE:  max_size  <= pwdata[LEN_BITS-1:0];
        REG_THRESHOLD: threshold <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_SIZE:  prdata = PDATA_W'(min_len);
      REG_MAX_SIZE:  prdata = PDATA_W'(max_size);
      REG_THRESHOLD: prdata = PDATA_W'(threshold);
      default:       prdata = '0;
    endcase
  end

  // window end is the larger of the two sizes, never zero so no chunk is empty
  always_comb begin
    end_pos = (max_size > min_len) ? max_size : min_len;
    if (end_pos == '0) begin
      end_pos = LEN_BITS'(1);
    end
    warm_start = (min_len > WARMUP_LEN) ? (min_len - WARMUP_LEN) : '0;
  end

  // ---------------------------------------------------------------------
  // input side: table writes go straight to the ram, bytes start a read
  // ---------------------------------------------------------------------
  assign s1_go           = s1_valid && (!out_valid || cut_chan.ready);
  assign in_ready        = !s1_valid || s1_go;
  assign byte_chan.ready = in_ready;
  assign in_fire         = byte_chan.valid && in_ready;
  assign in_func         = byte_chan.func;

  gcdc_ram #(
    .WIDTH (HASH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_gear_table (
    .clk   (clk),
    .we    (in_fire && (in_func == FUNC_TABLE)),
    .waddr (byte_chan.table_index),
    .wdata (byte_chan.table_value),
    .re    (in_fire && (in_func == FUNC_BYTE)),
    .raddr (byte_chan.data_byte),
    .rdata (gear_word)
  );

  // only bytes occupy the decision stage; the ram output holds while it stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_fire && (in_func == FUNC_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_func == FUNC_BYTE)) begin
      s1_last <= byte_chan.last;
    end
  end

  // ---------------------------------------------------------------------
  // decision stage: gear step, then the boundary test on the new hash
  // ---------------------------------------------------------------------
  always_comb begin
    // bytes ahead of the warm-up span leave the hash alone
    if (byte_position >= warm_start) begin
      hash_mixed = (rolling_hash << 1) + gear_word;
    end else begin
      hash_mixed = rolling_hash;
    end
    mask_clear = (hash_mixed & regress_mask) == '0;
    below_thr  = hash_mixed <= HASH_W'(threshold);
    // smear the leading one down; the tighter mask is every bit above it
    hash_smear = hash_mixed;
    for (int i = 0; i < HASH_SHIFTS; i++) begin
      hash_smear = hash_smear | (hash_smear >> (1 << i));
    end
    mask_tight = ~hash_smear;
    n_ext      = {1'b0, byte_position} + (LEN_BITS + 1)'(1);
  end

  always_comb begin
    s1_cut       = 1'b0;
    take_regress = 1'b0;
    cut_len      = n_ext[LEN_BITS-1:0];
    cut_reason   = REASON_WINDOW;
    priority if (s1_last && (n_ext <= {1'b0, min_len})) begin
      s1_cut     = 1'b1;
      cut_reason = REASON_SHORT;
    end else if (s1_last || (n_ext >= {1'b0, end_pos})) begin
      // final decision: best regression point if it still beats the end
      s1_cut = 1'b1;
      if (!mask_clear) begin
        cut_len    = regress_length;
        cut_reason = REASON_REGRESS;
      end
    end else if ((n_ext >= {1'b0, min_len}) && mask_clear) begin
      if (below_thr) begin
        s1_cut     = 1'b1;
        cut_reason = REASON_THRESH;
      end else begin
        take_regress = 1'b1;
      end
    end
  end

  // search state, restarted after every cut
  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_hash   <= '1;
      regress_mask   <= '0;
      regress_length <= '0;
      byte_position  <= '0;
    end else if (s1_go) begin
      if (s1_cut) begin
        rolling_hash   <= '1;
        regress_mask   <= '0;
        regress_length <= '0;
        byte_position  <= '0;
      end else begin
        rolling_hash  <= hash_mixed;
        byte_position <= n_ext[LEN_BITS-1:0];
        if (take_regress) begin
          regress_length <= n_ext[LEN_BITS-1:0];
          regress_mask   <= mask_tight;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cut_chan.ready) begin
        out_valid <= 1'b0;
      end
      if (s1_go && s1_cut) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_cut) begin
      out_len    <= cut_len;
      out_reason <= cut_reason;
    end
  end

  assign cut_chan.valid      = out_valid;
  assign cut_chan.cut_length = out_len;
  assign cut_chan.cut_reason = out_reason;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `include "gear_cdc_regression_cutpoint_defines.svh"

  assign state_fresh  = (byte_position == '0) && (regress_mask == '0) && (rolling_hash == '1);
  assign regress_fits = (regress_length != '0) && (regress_length <= byte_position);

  // a cut leaves the search state fresh for the next chunk
  `GCDC_ASSERT_NXT(a_cut_restarts, clk, rst, s1_go && s1_cut, state_fresh)
  // a live regression point lies inside the bytes seen so far
  `GCDC_ASSERT_IMP(a_regress_in_chunk, clk, rst, regress_mask != '0, regress_fits)
  // table writes never reach the decision stage
  `GCDC_ASSERT_NXT(a_write_skips_stage, clk, rst, in_fire && (in_func == FUNC_TABLE), !s1_valid)

endmodule

### dv/tb_top.sv
// self-checking testbench for the gear hash chunk boundary search
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gcdc_pkg::*;

  // stimulus sizing
  localparam int unsigned RAND_ITEMS    = 420;
  // a cut shows once the decision stage has moved its byte to the output register
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_SHOWN     = 10;

  localparam logic [LEN_BITS-1:0] SIZE_TOP   = LEN_BITS'(1048576);
  localparam logic [THRESH_W-1:0] THRESH_TOP = 32'h8000_0000;

  // gear table classes: a run of zero words, a run of small words, the rest random
  localparam int unsigned ZERO_WORDS     = 16;
  localparam int unsigned SMALL_WORDS    = 32;
  localparam int unsigned SMALL_WORD_MAX = 4095;

  typedef struct packed {
    logic [LEN_BITS-1:0] len;
    cut_reason_t         reason;
  } cut_t;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [BYTE_W-1:0] idx;
    logic [HASH_W-1:0] word;
  } chan_item_t;

  // byte content mixes: any byte, mostly zero-gear with rare small words, only zero-gear
  typedef enum {MIX_ANY, MIX_QUIET, MIX_FLAT} byte_mix_t;

  typedef enum {STEP_CFG, STEP_BYTE, STEP_TABLE} step_kind_t;

  // one row of the directed plan; typed rows carry the cut they must produce
  typedef struct {
    step_kind_t          kind;
    reg_index_t          reg_sel;
    logic [PDATA_W-1:0]  value;
    logic [BYTE_W-1:0]   data;
    int unsigned         reps;
    logic                last;
    logic [BYTE_W-1:0]   idx;
    logic [HASH_W-1:0]   word;
    bit                  typed;
    cut_t                want;
  } step_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gcdc_in_if  byte_if ();
  gcdc_out_if cut_if ();

  gear_cdc_regression_cutpoint dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .byte_chan (byte_if),
    .cut_chan  (cut_if)
  );

  // shadow of the block: gear table, search state and settings
  logic [HASH_W-1:0]   gear_q [TABLE_DEPTH];
  logic [HASH_W-1:0]   hash_q;
  logic [HASH_W-1:0]   mask_q;
  logic [LEN_BITS-1:0] regress_len_q;
  logic [LEN_BITS-1:0] pos_q;
  logic [LEN_BITS-1:0] min_q;
  logic [LEN_BITS-1:0] max_q;
  logic [THRESH_W-1:0] thr_q;

  // cuts still owed by the block, oldest first
  cut_t pending_cuts [$];

  int unsigned bad_cnt = 0;
  int unsigned cuts_seen = 0;
  int unsigned byte_items = 0;
  int unsigned tables_sent = 0;
  int unsigned phase_cnt = 0;
  int unsigned reason_hits [4] = '{0, 0, 0, 0};

  // pacing knobs, switched per phase so that some stretches run without idling
  bit tx_gap_on = 1'b1;
  bit rx_stall_on = 1'b1;

  function automatic void flag_error(string msg);
    bad_cnt++;
    if (bad_cnt <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // mostly zero, sometimes a few cycles, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned next_gap();
    return tx_gap_on ? pick_gap() : 0;
  endfunction

  function automatic logic [HASH_W-1:0] gear_word(int unsigned idx);
    if (idx < ZERO_WORDS) return '0;
    if (idx < SMALL_WORDS) return HASH_W'($urandom_range(1, SMALL_WORD_MAX));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte(byte_mix_t mix);
    case (mix)
      MIX_QUIET: begin
        if ($urandom_range(0, 31) == 0)
          return BYTE_W'($urandom_range(ZERO_WORDS, SMALL_WORDS - 1));
        return BYTE_W'($urandom_range(0, ZERO_WORDS - 1));
      end
      MIX_FLAT: return BYTE_W'($urandom_range(0, ZERO_WORDS - 1));
      default:  return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void restart_chunk();
    hash_q = '1;
    mask_q = '0;
    regress_len_q = '0;
    pos_q = '0;
  endfunction

  // tests one candidate boundary; a hash that clears the mask but not the
  // threshold becomes the new regression point with a tighter mask
  function automatic bit boundary_cut(logic [LEN_BITS-1:0] n);
    logic [HASH_W-1:0] m;
    if ((hash_q & mask_q) != '0) return 1'b0;
    if (hash_q <= HASH_W'(thr_q)) return 1'b1;
    regress_len_q = n;
    m = '1;
    // bits above the highest set bit; an all-ones hash leaves no bits
    while ((hash_q & m) != '0) m = m << 1;
    mask_q = m;
    return 1'b0;
  endfunction

  // advances the shadow by one transaction, returns 1 when a cut results
  function automatic bit cut_predict(chan_item_t it, output cut_t cut);
    logic [LEN_BITS:0] n;
    logic [LEN_BITS:0] end_at;
    logic [LEN_BITS:0] warm_at;
    cut.len = '0;
    cut.reason = REASON_SHORT;
    if (it.func == FUNC_TABLE) begin
      gear_q[it.idx] = it.word;
      return 1'b0;
    end
    // window ends at the larger size, never at zero
    end_at = {1'b0, (max_q > min_q) ? max_q : min_q};
    if (end_at == '0) end_at = (LEN_BITS + 1)'(1);
    warm_at = (min_q > WARMUP_LEN) ? {1'b0, min_q - WARMUP_LEN} : '0;
    // with no minimum the start itself is a candidate, tested on the initial hash
    if (pos_q == '0 && min_q == '0) void'(boundary_cut('0));
    if (pos_q >= warm_at) hash_q = (hash_q << 1) + gear_q[it.data];
    n = {1'b0, pos_q} + (LEN_BITS + 1)'(1);
    if (it.last && n <= min_q) begin
      cut.len = n[LEN_BITS-1:0];
      cut.reason = REASON_SHORT;
    end else if (it.last || n >= end_at) begin
      if ((hash_q & mask_q) != '0) begin
        cut.len = regress_len_q;
        cut.reason = REASON_REGRESS;
      end else begin
        cut.len = n[LEN_BITS-1:0];
        cut.reason = REASON_WINDOW;
      end
    end else if (n >= min_q && boundary_cut(n[LEN_BITS-1:0])) begin
      cut.len = n[LEN_BITS-1:0];
      cut.reason = REASON_THRESH;
    end else begin
      pos_q = n[LEN_BITS-1:0];
      return 1'b0;
    end
    restart_chunk();
    return 1'b1;
  endfunction

  function automatic step_t blank_step(step_kind_t k);
    step_t s;
    s.kind = k;
    s.reg_sel = REG_MIN_SIZE;
    s.value = '0;
    s.data = '0;
    s.reps = 1;
    s.last = 1'b0;
    s.idx = '0;
    s.word = '0;
    s.typed = 1'b0;
    s.want.len = '0;
    s.want.reason = REASON_SHORT;
    return s;
  endfunction

  function automatic step_t cfg_step(reg_index_t r, logic [PDATA_W-1:0] v);
    step_t s;
    s = blank_step(STEP_CFG);
    s.reg_sel = r;
    s.value = v;
    return s;
  endfunction

  function automatic step_t table_step(logic [BYTE_W-1:0] idx, logic [HASH_W-1:0] word);
    step_t s;
    s = blank_step(STEP_TABLE);
    s.idx = idx;
    s.word = word;
    return s;
  endfunction

  // a run of identical bytes; last applies to the final one only
  function automatic step_t byte_step(logic [BYTE_W-1:0] d, int unsigned reps, logic last);
    step_t s;
    s = blank_step(STEP_BYTE);
    s.data = d;
    s.reps = reps;
    s.last = last;
    return s;
  endfunction

  function automatic step_t byte_step_cut(logic [BYTE_W-1:0] d, int unsigned reps,
                                          logic last, int unsigned len, cut_reason_t why);
    step_t s;
    s = byte_step(d, reps, last);
    s.typed = 1'b1;
    s.want.len = LEN_BITS'(len);
    s.want.reason = why;
    return s;
  endfunction

  // one transaction on the byte channel; the shadow advances at the accepting edge
  task automatic send_item(chan_item_t it, int unsigned gap, bit typed, cut_t typed_cut);
    cut_t cut;
    bit made;
    repeat (gap) begin
      @(negedge clk);
      byte_if.valid <= 1'b0;
    end
    @(negedge clk);
    byte_if.valid       <= 1'b1;
    byte_if.func        <= it.func;
    byte_if.data_byte   <= it.data;
    byte_if.last        <= it.last;
    byte_if.table_index <= it.idx;
    byte_if.table_value <= it.word;
    do @(posedge clk); while (byte_if.ready !== 1'b1);
    made = cut_predict(it, cut);
    // a typed row overrides the shadow with the cut read off by hand
    if (typed) pending_cuts.insert(pending_cuts.size(), typed_cut);
    else if (made) pending_cuts.insert(pending_cuts.size(), cut);
    if (it.func == FUNC_TABLE) tables_sent++;
    else byte_items++;
  endtask

  // waits until every owed cut has arrived and the pipeline is empty
  task automatic drain_cuts();
    @(negedge clk);
    byte_if.valid <= 1'b0;
    while (pending_cuts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic reg_write(reg_index_t r, logic [PDATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (r)
      REG_MIN_SIZE:  min_q = v[LEN_BITS-1:0];
      REG_MAX_SIZE:  max_q = v[LEN_BITS-1:0];
      REG_THRESHOLD: thr_q = v[THRESH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // free-running clock, 10 ns period
  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin : watchdog
    #5ms;
    $display("[%0t] timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

  // result side pacing: ready drops for random stretches when enabled
  initial begin : rx_pacing
    int unsigned hold;
    hold = 0;
    cut_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && rx_stall_on) hold = pick_gap();
      if (hold != 0) begin
        cut_if.ready <= 1'b0;
        hold--;
      end else begin
        cut_if.ready <= 1'b1;
      end
    end
  end

  // each accepted cut is compared with the oldest owed one
  always @(posedge clk) begin : cut_check
    cut_t want;
    cut_t seen;
    if (!rst && cut_if.valid === 1'b1 && cut_if.ready === 1'b1) begin
      seen.len = cut_if.cut_length;
      seen.reason = cut_reason_t'(cut_if.cut_reason);
      cuts_seen++;
      reason_hits[cut_if.cut_reason]++;
      if (pending_cuts.size() == 0) begin
        flag_error($sformatf("cut with nothing owed: length %0d reason %0d",
                             seen.len, seen.reason));
      end else begin
        want = pending_cuts.pop_front();
        if (seen.len !== want.len)
          flag_error($sformatf("cut length %0d, expected %0d", seen.len, want.len));
        if (seen.reason !== want.reason)
          flag_error($sformatf("cut reason %0d, expected %0d (length %0d)",
                               seen.reason, want.reason, want.len));
      end
    end
  end

  initial begin : stimulus
    step_t       plan [$];
    step_t       st;
    chan_item_t  it;
    cut_t        none;
    byte_mix_t   mix;
    int unsigned rand_items;
    int unsigned phase_len;
    int unsigned sel;
    bit          wrote;
    logic [LEN_BITS-1:0] size_pick;
    logic [THRESH_W-1:0] thr_pick;

    // every input at a known level from time zero
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_if.valid = 1'b0;
    byte_if.func = FUNC_BYTE;
    byte_if.data_byte = '0;
    byte_if.last = 1'b0;
    byte_if.table_index = '0;
    byte_if.table_value = '0;
    none.len = '0;
    none.reason = REASON_SHORT;

    // shadow reset: search state restarted, settings at their reset values
    restart_chunk();
    min_q = MIN_SIZE_RST;
    max_q = MAX_SIZE_RST;
    thr_q = THRESHOLD_RST;
    foreach (gear_q[i]) gear_q[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the whole gear table first, so no byte ever reads an unwritten word
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      it.func = FUNC_TABLE;
      it.idx = BYTE_W'(i);
      it.word = gear_word(i);
      it.data = BYTE_W'($urandom);
      it.last = 1'b0;
      send_item(it, next_gap(), 1'b0, none);
    end

    // directed plan
    // reset settings: a single last byte is short data
    plan.insert(plan.size(), byte_step_cut(8'hFF, 1, 1'b1, 1, REASON_SHORT));
    // no minimum and no maximum: window of one byte, the start is tested on
    // the all-ones hash and leaves an empty regression mask
    plan.insert(plan.size(), cfg_step(REG_MIN_SIZE, '0));
    plan.insert(plan.size(), cfg_step(REG_MAX_SIZE, '0));
    plan.insert(plan.size(), byte_step_cut(8'h00, 1, 1'b0, 1, REASON_WINDOW));
    // largest window, data end past the minimum
    plan.insert(plan.size(), cfg_step(REG_MAX_SIZE, PDATA_W'(SIZE_TOP)));
    plan.insert(plan.size(), byte_step(8'hFF, 3, 1'b1));
    // zero threshold: 64 zero-gear bytes flush the hash to zero right at the minimum
    plan.insert(plan.size(), cfg_step(REG_THRESHOLD, '0));
    plan.insert(plan.size(), cfg_step(REG_MIN_SIZE, 32'd64));
    plan.insert(plan.size(), cfg_step(REG_MAX_SIZE, 32'd200));
    plan.insert(plan.size(), byte_step_cut(8'h00, 64, 1'b0, 64, REASON_THRESH));
    // maximum below minimum: window ends at the minimum with no candidate tested
    plan.insert(plan.size(), cfg_step(REG_MIN_SIZE, 32'd10));
    plan.insert(plan.size(), cfg_step(REG_MAX_SIZE, 32'd3));
    plan.insert(plan.size(), byte_step_cut(8'hA5, 10, 1'b0, 10, REASON_WINDOW));
    // top threshold, short window, table writes in the middle of a chunk
    plan.insert(plan.size(), cfg_step(REG_THRESHOLD, PDATA_W'(THRESH_TOP)));
    plan.insert(plan.size(), cfg_step(REG_MIN_SIZE, 32'd4));
    plan.insert(plan.size(), cfg_step(REG_MAX_SIZE, 32'd40));
    plan.insert(plan.size(), byte_step(8'h5A, 2, 1'b0));
    plan.insert(plan.size(), table_step(8'hFE, '1));
    plan.insert(plan.size(), table_step(8'h01, '0));
    plan.insert(plan.size(), byte_step(8'hFE, 1, 1'b0));
    plan.insert(plan.size(), byte_step(8'h3C, 40, 1'b1));
    // largest minimum and maximum: only short data can end a chunk here
    plan.insert(plan.size(), cfg_step(REG_MIN_SIZE, PDATA_W'(SIZE_TOP)));
    plan.insert(plan.size(), cfg_step(REG_MAX_SIZE, PDATA_W'(SIZE_TOP)));
    plan.insert(plan.size(), byte_step_cut(8'h80, 3, 1'b1, 3, REASON_SHORT));

    foreach (plan[s]) begin
      st = plan[s];
      if (st.kind == STEP_CFG) begin
        drain_cuts();
        reg_write(st.reg_sel, st.value);
      end else if (st.kind == STEP_TABLE) begin
        it.func = FUNC_TABLE;
        it.idx = st.idx;
        it.word = st.word;
        it.data = '0;
        it.last = 1'b0;
        send_item(it, next_gap(), st.typed, st.want);
      end else begin
        for (int k = 0; k < st.reps; k++) begin
          it.func = FUNC_BYTE;
          it.data = st.data;
          it.last = (k == st.reps - 1) ? st.last : 1'b0;
          it.idx = '0;
          it.word = '0;
          send_item(it, next_gap(), st.typed && (k == st.reps - 1), st.want);
        end
      end
    end

    // random phases: new settings while idle, then a stream of chunks whose
    // content mix drifts between random and low-entropy data
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      drain_cuts();
      phase_cnt++;
      wrote = 1'b0;

      if ($urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) size_pick = '0;
        else if (sel <= 6) size_pick = LEN_BITS'($urandom_range(1, 63));
        else if (sel <= 8) size_pick = LEN_BITS'($urandom_range(64, 160));
        else size_pick = SIZE_TOP;
        reg_write(REG_MIN_SIZE, PDATA_W'(size_pick));
        wrote = 1'b1;
      end

      if ($urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 9);
        // maximum at or below the minimum, the top, or a little above the minimum
        if (sel == 0) size_pick = LEN_BITS'($urandom_range(1, (min_q == '0) ? 1 : min_q));
        else if (sel == 1 || min_q > SIZE_TOP - 120) size_pick = SIZE_TOP;
        else size_pick = min_q + LEN_BITS'($urandom_range(1, 120));
        reg_write(REG_MAX_SIZE, PDATA_W'(size_pick));
        wrote = 1'b1;
      end

      if (!wrote || $urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 5);
        if (sel == 0) thr_pick = '0;
        else if (sel == 1) thr_pick = THRESH_TOP;
        else if (sel == 2) thr_pick = THRESHOLD_RST;
        else thr_pick = $urandom >> $urandom_range(1, 31);
        reg_write(REG_THRESHOLD, PDATA_W'(thr_pick));
      end

      tx_gap_on = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      mix = byte_mix_t'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 110);

      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 31) == 0) mix = byte_mix_t'($urandom_range(0, 2));
        if ($urandom_range(0, 24) == 0) begin
          // gear table rewrite; the class of each entry is kept
          it.func = FUNC_TABLE;
          it.idx = BYTE_W'($urandom_range(0, 255));
          it.word = gear_word(it.idx);
          it.data = BYTE_W'($urandom);
          it.last = 1'($urandom);
        end else begin
          it.func = FUNC_BYTE;
          it.data = pick_byte(mix);
          it.last = ($urandom_range(0, 59) == 0);
          it.idx = BYTE_W'($urandom);
          it.word = {$urandom, $urandom};
        end
        send_item(it, next_gap(), 1'b0, none);
        rand_items++;
      end

      // close the phase on a chunk boundary before settings change
      it.func = FUNC_BYTE;
      it.data = pick_byte(mix);
      it.last = 1'b1;
      send_item(it, next_gap(), 1'b0, none);
      rand_items++;
    end

    drain_cuts();
    foreach (pending_cuts[i])
      flag_error($sformatf("cut never arrived: length %0d reason %0d",
                           pending_cuts[i].len, pending_cuts[i].reason));

    $display("run covered %0d window bytes and %0d gear table writes over %0d random phases",
             byte_items, tables_sent, phase_cnt);
    $display("%0d cuts checked: %0d short, %0d threshold, %0d regression, %0d window end",
             cuts_seen, reason_hits[0], reason_hits[1], reason_hits[2], reason_hits[3]);
    if (bad_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/gcdc_pkg.sv
src/gcdc_chan_if.sv
src/gcdc_ram.sv
src/gear_cdc_regression_cutpoint.sv
dv/tb_top.sv
